[rtl/i2c_bitbang_master_top_macros.svh]
// assertion macros used by the i2c bit-bang master sequencer
`ifndef I2C_BITBANG_MASTER_TOP_MACROS_SVH
`define I2C_BITBANG_MASTER_TOP_MACROS_SVH
`ifndef SYNTH
// property checked on every clock edge outside reset
`define I2C_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("i2c bit-bang master check failed");
// consequent checked in the cycle after the antecedent
`define I2C_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c bit-bang master sequence check failed");
`else
`define I2C_ASSERT(label, clk, rst_n, prop)
`define I2C_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/i2c_bb_pkg.sv]
// types and constants of the i2c bit-bang master
package i2c_bb_pkg;

    localparam int BYTE_BITS = 8;

    // command codes
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_SEND  = 3'd3,
        CMD_WAIT  = 3'd4,
        CMD_READ  = 3'd5
    } t_cmd;

    // register word indexes
    localparam logic [1:0] REG_SHORT_DELAY = 2'd0;
    localparam logic [1:0] REG_LONG_DELAY  = 2'd1;
    localparam logic [1:0] REG_ACK_SETTLE  = 2'd2;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd3;

    // register reset values
    localparam logic [7:0] RST_SHORT_DELAY = 8'd2;
    localparam logic [7:0] RST_LONG_DELAY  = 8'd4;
    localparam logic [7:0] RST_ACK_SETTLE  = 8'd1;
    localparam logic [7:0] RST_ACK_TIMEOUT = 8'd250;

    // sequencer phase codes; PH_0 to PH_2 are used by more than one command
    localparam logic [2:0] PH_0 = 3'd0;
    localparam logic [2:0] PH_1 = 3'd1;
    localparam logic [2:0] PH_2 = 3'd2;
    localparam logic [2:0] PH_3 = 3'd3;
    localparam logic [2:0] PH_4 = 3'd4;

    typedef struct packed {
        logic [7:0] short_delay;
        logic [7:0] long_delay;
        logic [7:0] ack_settle;
        logic [7:0] ack_timeout;
    } t_cfg;

    typedef struct packed {
        logic       scl;
        logic       sda_release;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } t_result;

    // a zero delay still lasts one tick
    function automatic logic [7:0] load_ticks(input logic [7:0] ticks);
        load_ticks = (ticks == 8'd0) ? 8'd1 : ticks;
    endfunction

endpackage

[rtl/i2c_bb_regs.sv]
// apb configuration registers of the i2c bit-bang master
module i2c_bb_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output i2c_bb_pkg::t_cfg   o_cfg
);
    import i2c_bb_pkg::*;

    logic [7:0] r_short_delay;
    logic [7:0] r_long_delay;
    logic [7:0] r_ack_settle;
    logic [7:0] r_ack_timeout;
    logic       w_write;
    logic [1:0] w_index;
    logic [7:0] w_rdata;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[3:2];

    // register write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_delay <= RST_SHORT_DELAY;
            r_long_delay  <= RST_LONG_DELAY;
            r_ack_settle  <= RST_ACK_SETTLE;
            r_ack_timeout <= RST_ACK_TIMEOUT;
        end else if (w_write) begin
            case (w_index)
                REG_SHORT_DELAY: r_short_delay <= pwdata[7:0];
                REG_LONG_DELAY:  r_long_delay  <= pwdata[7:0];
                REG_ACK_SETTLE:  r_ack_settle  <= pwdata[7:0];
                REG_ACK_TIMEOUT: r_ack_timeout <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_index)
            REG_SHORT_DELAY: w_rdata = r_short_delay;
            REG_LONG_DELAY:  w_rdata = r_long_delay;
            REG_ACK_SETTLE:  w_rdata = r_ack_settle;
            REG_ACK_TIMEOUT: w_rdata = r_ack_timeout;
            default:         w_rdata = 8'd0;
        endcase
    end

    assign prdata = {24'd0, w_rdata};

    assign o_cfg.short_delay = r_short_delay;
    assign o_cfg.long_delay  = r_long_delay;
    assign o_cfg.ack_settle  = r_ack_settle;
    assign o_cfg.ack_timeout = r_ack_timeout;

endmodule

[rtl/i2c_bb_seq.sv]
// pin sequencer state and its one-tick next-state logic
`include "i2c_bitbang_master_top_macros.svh"
module i2c_bb_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [2:0]            i_func,
    input  logic [7:0]            i_tx_byte,
    input  logic                  i_send_ack,
    input  logic                  i_sda_in,
    input  i2c_bb_pkg::t_cfg      i_cfg,
    output i2c_bb_pkg::t_result   o_res
);
    import i2c_bb_pkg::*;

    t_cmd                 r_cmd,   n_cmd;
    logic [2:0]           r_phase, n_phase;
    logic [3:0]           r_bit,   n_bit;
    logic [BYTE_BITS-1:0] r_shift, n_shift;
    logic [7:0]           r_delay, n_delay;
    logic [7:0]           r_tmo,   n_tmo;
    logic                 r_ack,   n_ack;
    logic                 r_scl,   n_scl;
    logic                 r_sda,   n_sda;
    logic                 r_dir,   n_dir;
    logic                 r_fail,  n_fail;
    logic [7:0]           r_rx,    n_rx;
    logic                 w_finish;
    logic [3:0]           w_bit_inc;

    assign w_bit_inc = r_bit + 4'd1;

    // state registers advance once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= CMD_IDLE;
            r_phase <= PH_0;
            r_bit   <= 4'd0;
            r_shift <= '0;
            r_delay <= 8'd0;
            r_tmo   <= 8'd0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_dir   <= 1'b1;
            r_fail  <= 1'b0;
            r_rx    <= 8'd0;
        end else if (i_step) begin
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_delay <= n_delay;
            r_tmo   <= n_tmo;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_dir   <= n_dir;
            r_fail  <= n_fail;
            r_rx    <= n_rx;
        end
    end

    // next state for one tick
    always_comb begin
        n_cmd    = r_cmd;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_delay  = r_delay;
        n_tmo    = r_tmo;
        n_ack    = r_ack;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_dir    = r_dir;
        n_fail   = r_fail;
        n_rx     = r_rx;
        w_finish = 1'b0;

        if (r_cmd == CMD_IDLE) begin
            // command accept
            n_bit = 4'd0;
            case (i_func)
                CMD_START: begin
                    n_cmd   = CMD_START;
                    n_dir   = 1'b1;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_delay = load_ticks(i_cfg.long_delay);
                    n_phase = PH_0;
                end
                CMD_STOP: begin
                    n_cmd   = CMD_STOP;
                    n_dir   = 1'b1;
                    n_scl   = 1'b0;
                    n_sda   = 1'b0;
                    n_delay = load_ticks(i_cfg.long_delay);
                    n_phase = PH_0;
                end
                CMD_SEND: begin
                    n_cmd   = CMD_SEND;
                    n_dir   = 1'b1;
                    n_scl   = 1'b0;
                    n_sda   = i_tx_byte[BYTE_BITS-1];
                    n_shift = {i_tx_byte[BYTE_BITS-2:0], 1'b0};
                    n_delay = load_ticks(i_cfg.short_delay);
                    n_phase = PH_0;
                end
                CMD_WAIT: begin
                    n_cmd   = CMD_WAIT;
                    n_dir   = 1'b0;
                    n_sda   = 1'b1;
                    n_delay = load_ticks(i_cfg.ack_settle);
                    n_phase = PH_0;
                end
                CMD_READ: begin
                    n_cmd   = CMD_READ;
                    n_dir   = 1'b0;
                    n_sda   = 1'b1;
                    n_scl   = 1'b0;
                    n_shift = '0;
                    n_ack   = i_send_ack;
                    n_delay = load_ticks(i_cfg.long_delay);
                    n_phase = PH_0;
                end
                default: ;
            endcase
        end else if (r_cmd == CMD_WAIT && r_phase == PH_2) begin
            // acknowledge polling with timeout
            if (!i_sda_in) begin
                n_scl    = 1'b0;
                n_fail   = 1'b0;
                w_finish = 1'b1;
            end else if (r_tmo >= i_cfg.ack_timeout) begin
                n_fail  = 1'b1;
                n_cmd   = CMD_STOP;
                n_dir   = 1'b1;
                n_scl   = 1'b0;
                n_sda   = 1'b0;
                n_delay = load_ticks(i_cfg.long_delay);
                n_phase = PH_0;
            end else begin
                n_tmo = r_tmo + 8'd1;
            end
        end else if (r_delay > 8'd1) begin
            n_delay = r_delay - 8'd1;
        end else begin
            // phase end
            case (r_cmd)
                CMD_START: begin
                    if (r_phase == PH_0) begin
                        n_sda   = 1'b0;
                        n_delay = load_ticks(i_cfg.long_delay);
                        n_phase = PH_1;
                    end else begin
                        n_scl    = 1'b0;
                        w_finish = 1'b1;
                    end
                end
                CMD_STOP: begin
                    if (r_phase == PH_0) begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_delay = load_ticks(i_cfg.long_delay);
                        n_phase = PH_1;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
                CMD_SEND: begin
                    if (r_phase == PH_0) begin
                        n_scl   = 1'b1;
                        n_delay = load_ticks(i_cfg.short_delay);
                        n_phase = PH_1;
                    end else if (r_phase == PH_1) begin
                        n_scl   = 1'b0;
                        n_delay = load_ticks(i_cfg.short_delay);
                        n_phase = PH_2;
                    end else begin
                        n_bit = w_bit_inc;
                        if (w_bit_inc >= 4'(BYTE_BITS)) begin
                            w_finish = 1'b1;
                        end else begin
                            n_sda   = r_shift[BYTE_BITS-1];
                            n_shift = {r_shift[BYTE_BITS-2:0], 1'b0};
                            n_delay = load_ticks(i_cfg.short_delay);
                            n_phase = PH_0;
                        end
                    end
                end
                CMD_WAIT: begin
                    if (r_phase == PH_0) begin
                        n_scl   = 1'b1;
                        n_delay = load_ticks(i_cfg.ack_settle);
                        n_phase = PH_1;
                    end else begin
                        n_phase = PH_2;
                        n_tmo   = 8'd0;
                    end
                end
                CMD_READ: begin
                    if (r_phase == PH_0) begin
                        n_scl   = 1'b1;
                        n_delay = load_ticks(i_cfg.long_delay);
                        n_phase = PH_1;
                    end else if (r_phase == PH_1) begin
                        // sample sda at the end of scl high
                        n_shift = {r_shift[BYTE_BITS-2:0], i_sda_in};
                        n_scl   = 1'b0;
                        n_delay = load_ticks(i_cfg.long_delay);
                        n_phase = PH_2;
                    end else if (r_phase == PH_2) begin
                        n_bit = w_bit_inc;
                        if (w_bit_inc < 4'(BYTE_BITS)) begin
                            n_delay = load_ticks(i_cfg.long_delay);
                            n_phase = PH_0;
                        end else begin
                            n_dir   = 1'b1;
                            n_scl   = 1'b0;
                            n_delay = load_ticks(i_cfg.short_delay);
                            n_phase = PH_3;
                        end
                    end else if (r_phase == PH_3) begin
                        n_sda   = !r_ack;
                        n_scl   = 1'b1;
                        n_delay = load_ticks(i_cfg.short_delay);
                        n_phase = PH_4;
                    end else begin
                        n_scl    = 1'b0;
                        n_rx     = r_shift;
                        w_finish = 1'b1;
                    end
                end
                default: w_finish = 1'b1;
            endcase
        end

        // command complete returns to idle
        if (w_finish) begin
            n_cmd   = CMD_IDLE;
            n_phase = PH_0;
            n_delay = 8'd0;
        end
    end

    // result of this tick
    assign o_res.scl         = n_scl;
    assign o_res.sda_release = n_sda;
    assign o_res.sda_drive   = n_dir;
    assign o_res.busy_res    = (n_cmd != CMD_IDLE);
    assign o_res.done_res    = w_finish;
    assign o_res.rx_byte     = n_rx;
    assign o_res.ack_failed  = n_fail;

    // finished command leaves the sequencer idle
    `I2C_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, i_step && w_finish, r_cmd == CMD_IDLE)
    // a timed phase never holds an empty delay count
    `I2C_ASSERT(a_delay_loaded, i_clk, i_rst_n, r_cmd == CMD_IDLE || (r_cmd == CMD_WAIT && r_phase == PH_2) || r_delay != 8'd0)
    // bit counter stays within one byte
    `I2C_ASSERT(a_bit_range, i_clk, i_rst_n, r_bit <= 4'(BYTE_BITS))

endmodule

[rtl/i2c_bitbang_master_top.sv]
// i2c bit-bang master: input register, sequencer, result register, apb registers
// an accepted tick is held in the input register until it moves on into the result register
// throughput: one tick per cycle unless the result stalls; both registers decouple the sides
// each tick is one pass of the sequencer next-state logic between the two registers
// reset (synchronous, active low) empties both registers, idles the sequencer
// and restores the configuration registers to their defaults
module i2c_bitbang_master_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_send_ack,
    input  logic        i_sda_in,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl,
    output logic        o_sda_release,
    output logic        o_sda_drive,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [7:0]  o_rx_byte,
    output logic        o_ack_failed,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2c_bb_pkg::*;

    t_cfg       w_cfg;
    t_result    w_res;
    logic       w_step;
    logic       r_in_valid;
    logic [2:0] r_func;
    logic [7:0] r_tx_byte;
    logic       r_send_ack;
    logic       r_sda_in;
    logic       r_out_valid;
    t_result    r_out;

    i2c_bb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // a held tick moves on when the result register is free
    assign w_step     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_func     <= i_func;
            r_tx_byte  <= i_tx_byte;
            r_send_ack <= i_send_ack;
            r_sda_in   <= i_sda_in;
        end
    end

    i2c_bb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_func     (r_func),
        .i_tx_byte  (r_tx_byte),
        .i_send_ack (r_send_ack),
        .i_sda_in   (r_sda_in),
        .i_cfg      (w_cfg),
        .o_res      (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl         = r_out.scl;
    assign o_sda_release = r_out.sda_release;
    assign o_sda_drive   = r_out.sda_drive;
    assign o_busy_res    = r_out.busy_res;
    assign o_done_res    = r_out.done_res;
    assign o_rx_byte     = r_out.rx_byte;
    assign o_ack_failed  = r_out.ack_failed;

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the i2c bit-bang master: tick stream, apb setup, result scoreboard
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_bb_pkg::*;

    // line behavior the stimulus applies to sda_in
    localparam int SDA_RANDOM = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_LOW    = 2;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_func      = CMD_IDLE;
    logic [7:0]  i_tx_byte   = 8'h00;
    logic        i_send_ack  = 1'b0;
    logic        i_sda_in    = 1'b1;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_scl;
    logic        o_sda_release;
    logic        o_sda_drive;
    logic        o_busy_res;
    logic        o_done_res;
    logic [7:0]  o_rx_byte;
    logic        o_ack_failed;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = 4'h0;
    logic [31:0] pwdata      = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    i2c_bitbang_master_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_tx_byte     (i_tx_byte),
        .i_send_ack    (i_send_ack),
        .i_sda_in      (i_sda_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_scl         (o_scl),
        .o_sda_release (o_sda_release),
        .o_sda_drive   (o_sda_drive),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_rx_byte     (o_rx_byte),
        .o_ack_failed  (o_ack_failed),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow copy of the sequencer and its registers
    t_cmd       seq_cmd   = CMD_IDLE;
    logic [2:0] seq_phase = PH_0;
    logic [3:0] seq_bit   = 4'd0;
    logic [7:0] seq_shift = 8'h00;
    logic [7:0] seq_delay = 8'h00;
    logic [7:0] seq_wait  = 8'h00;
    logic       seq_ack   = 1'b0;
    logic       seq_scl   = 1'b1;
    logic       seq_sda   = 1'b1;
    logic       seq_dir   = 1'b1;
    logic       seq_fail  = 1'b0;
    logic [7:0] seq_rx    = 8'h00;
    t_cfg       cfg       = '{RST_SHORT_DELAY, RST_LONG_DELAY, RST_ACK_SETTLE, RST_ACK_TIMEOUT};

    t_result    line_q[$];
    logic [2:0] plan_q[$];
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         sda_mode      = SDA_RANDOM;
    int         n_fail        = 0;
    int         n_ticks       = 0;
    int         n_done        = 0;
    int         n_timeouts    = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // phase timer load, zero counts as one tick
    function automatic void load_phase(input logic [7:0] ticks, input logic [2:0] nxt);
        seq_delay = (ticks == 8'd0) ? 8'd1 : ticks;
        seq_phase = nxt;
    endfunction

    // drive next data bit msb first
    function automatic void shift_out_bit();
        seq_sda   = seq_shift[7];
        seq_shift = seq_shift << 1;
        load_phase(cfg.short_delay, PH_0);
    endfunction

    function automatic void enter_stop();
        seq_cmd = CMD_STOP;
        seq_dir = 1'b1;
        seq_scl = 1'b0;
        seq_sda = 1'b0;
        load_phase(cfg.long_delay, PH_0);
    endfunction

    // one busy tick, returns 1 when the command completes
    function automatic logic advance_tick(input logic sda);
        // ack polling runs every tick, not on the phase timer
        if (seq_cmd == CMD_WAIT && seq_phase == PH_2) begin
            if (!sda) begin
                seq_scl  = 1'b0;
                seq_fail = 1'b0;
                return 1'b1;
            end
            if (seq_wait >= cfg.ack_timeout) begin
                seq_fail = 1'b1;
                n_timeouts++;
                enter_stop();
                return 1'b0;
            end
            seq_wait++;
            return 1'b0;
        end
        if (seq_delay > 8'd1) begin
            seq_delay--;
            return 1'b0;
        end
        case (seq_cmd)
            CMD_START: begin
                if (seq_phase == PH_0) begin
                    seq_sda = 1'b0;
                    load_phase(cfg.long_delay, PH_1);
                    return 1'b0;
                end
                seq_scl = 1'b0;
                return 1'b1;
            end
            CMD_STOP: begin
                if (seq_phase == PH_0) begin
                    seq_scl = 1'b1;
                    seq_sda = 1'b1;
                    load_phase(cfg.long_delay, PH_1);
                    return 1'b0;
                end
                return 1'b1;
            end
            CMD_SEND: begin
                if (seq_phase == PH_0) begin
                    seq_scl = 1'b1;
                    load_phase(cfg.short_delay, PH_1);
                    return 1'b0;
                end
                if (seq_phase == PH_1) begin
                    seq_scl = 1'b0;
                    load_phase(cfg.short_delay, PH_2);
                    return 1'b0;
                end
                seq_bit++;
                if (seq_bit >= BYTE_BITS) return 1'b1;
                shift_out_bit();
                return 1'b0;
            end
            CMD_WAIT: begin
                if (seq_phase == PH_0) begin
                    seq_scl = 1'b1;
                    load_phase(cfg.ack_settle, PH_1);
                    return 1'b0;
                end
                seq_phase = PH_2;
                seq_wait  = 8'd0;
                return 1'b0;
            end
            CMD_READ: begin
                if (seq_phase == PH_0) begin
                    seq_scl = 1'b1;
                    load_phase(cfg.long_delay, PH_1);
                    return 1'b0;
                end
                // sample at the end of scl high
                if (seq_phase == PH_1) begin
                    seq_shift = {seq_shift[6:0], sda};
                    seq_scl   = 1'b0;
                    load_phase(cfg.long_delay, PH_2);
                    return 1'b0;
                end
                if (seq_phase == PH_2) begin
                    seq_bit++;
                    if (seq_bit < BYTE_BITS) begin
                        load_phase(cfg.long_delay, PH_0);
                        return 1'b0;
                    end
                    seq_dir = 1'b1;
                    seq_scl = 1'b0;
                    load_phase(cfg.short_delay, PH_3);
                    return 1'b0;
                end
                // ack or nack bit
                if (seq_phase == PH_3) begin
                    seq_sda = ~seq_ack;
                    seq_scl = 1'b1;
                    load_phase(cfg.short_delay, PH_4);
                    return 1'b0;
                end
                seq_scl = 1'b0;
                seq_rx  = seq_shift;
                return 1'b1;
            end
            default: return 1'b1;
        endcase
    endfunction

    // expected line state after one tick
    function automatic t_result step_sequencer(input logic [2:0] f, input logic [7:0] tx,
                                               input logic snd, input logic sda);
        t_result r;
        logic    fin;
        fin = 1'b0;
        if (seq_cmd == CMD_IDLE) begin
            seq_bit = 4'd0;
            case (f)
                CMD_START: begin
                    seq_cmd = CMD_START;
                    seq_dir = 1'b1;
                    seq_scl = 1'b1;
                    seq_sda = 1'b1;
                    load_phase(cfg.long_delay, PH_0);
                end
                CMD_STOP: enter_stop();
                CMD_SEND: begin
                    seq_cmd   = CMD_SEND;
                    seq_dir   = 1'b1;
                    seq_scl   = 1'b0;
                    seq_shift = tx;
                    shift_out_bit();
                end
                CMD_WAIT: begin
                    seq_cmd = CMD_WAIT;
                    seq_dir = 1'b0;
                    seq_sda = 1'b1;
                    load_phase(cfg.ack_settle, PH_0);
                end
                CMD_READ: begin
                    seq_cmd   = CMD_READ;
                    seq_dir   = 1'b0;
                    seq_sda   = 1'b1;
                    seq_scl   = 1'b0;
                    seq_shift = 8'h00;
                    seq_ack   = snd;
                    load_phase(cfg.long_delay, PH_0);
                end
                default: ;
            endcase
        end else if (advance_tick(sda)) begin
            fin       = 1'b1;
            n_done++;
            seq_cmd   = CMD_IDLE;
            seq_phase = PH_0;
            seq_delay = 8'd0;
        end
        r.scl         = seq_scl;
        r.sda_release = seq_sda;
        r.sda_drive   = seq_dir;
        r.busy_res    = (seq_cmd != CMD_IDLE);
        r.done_res    = fin;
        r.rx_byte     = seq_rx;
        r.ack_failed  = seq_fail;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    // result scoreboard, one check per accepted transfer
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (line_q.size() == 0) begin
                $error("result transfer with no tick pending");
                n_fail++;
            end else begin
                want = line_q.pop_front();
                check_field("scl", 8'(want.scl), 8'(o_scl));
                check_field("sda_release", 8'(want.sda_release), 8'(o_sda_release));
                check_field("sda_drive", 8'(want.sda_drive), 8'(o_sda_drive));
                check_field("busy_res", 8'(want.busy_res), 8'(o_busy_res));
                check_field("done_res", 8'(want.done_res), 8'(o_done_res));
                check_field("rx_byte", want.rx_byte, o_rx_byte);
                check_field("ack_failed", 8'(want.ack_failed), 8'(o_ack_failed));
            end
        end
    end

    function automatic logic line_sda();
        case (sda_mode)
            SDA_HIGH: return 1'b1;
            SDA_LOW:  return 1'b0;
            default:  return ($urandom_range(3) != 0);
        endcase
    endfunction

    // one tick transfer with optional idle cycles ahead of it
    task automatic send_tick(input logic [2:0] f, input logic [7:0] tx, input logic snd,
                             input logic sda);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_tx_byte  <= tx;
        i_send_ack <= snd;
        i_sda_in   <= sda;
        do @(posedge i_clk); while (o_in_stall);
        line_q.push_back(step_sequencer(f, tx, snd, sda));
        n_ticks++;
    endtask

    // hold off new ticks until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (line_q.size() != 0) @(posedge i_clk);
    endtask

    // issue a command, then tick with random ignored fields until it completes
    task automatic run_cmd(input logic [2:0] f, input logic [7:0] tx, input logic snd,
                           input int mode);
        sda_mode = mode;
        send_tick(f, tx, snd, line_sda());
        while (seq_cmd != CMD_IDLE)
            send_tick(3'($urandom_range(7)), 8'($urandom), 1'($urandom), line_sda());
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SHORT_DELAY: cfg.short_delay = val;
            REG_LONG_DELAY:  cfg.long_delay  = val;
            REG_ACK_SETTLE:  cfg.ack_settle  = val;
            default:         cfg.ack_timeout = val;
        endcase
    endtask

    // registers change only with the pipeline empty and the sequencer idle
    task automatic set_config(input logic [7:0] sd, input logic [7:0] ld,
                              input logic [7:0] st, input logic [7:0] to);
        drain_results();
        apb_write(REG_SHORT_DELAY, sd);
        apb_write(REG_LONG_DELAY, ld);
        apb_write(REG_ACK_SETTLE, st);
        apb_write(REG_ACK_TIMEOUT, to);
    endtask

    // every command once with reset register values
    task automatic test_defaults();
        send_idle_pct = 0;
        stall_pct     = 0;
        run_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
        run_cmd(CMD_SEND, 8'hA5, 1'b0, SDA_RANDOM);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_LOW);
        run_cmd(CMD_READ, 8'h00, 1'b1, SDA_RANDOM);
        run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
    endtask

    // tick-only and unused codes leave the sequencer idle
    task automatic test_unused_codes();
        send_idle_pct = 65;
        stall_pct     = 0;
        run_cmd(CMD_IDLE, 8'hFF, 1'b1, SDA_RANDOM);
        run_cmd(3'd6, 8'h5A, 1'b0, SDA_RANDOM);
        run_cmd(3'd7, 8'hC3, 1'b1, SDA_RANDOM);
    endtask

    // ack that never comes, auto stop, then a good ack clears the flag
    task automatic test_ack_timeout();
        send_idle_pct = 26;
        stall_pct     = 26;
        set_config(RST_SHORT_DELAY, RST_LONG_DELAY, RST_ACK_SETTLE, 8'd12);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_HIGH);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_LOW);
    endtask

    // zero in every register acts as one tick, zero timeout fails at once
    task automatic test_zero_delays();
        send_idle_pct = 0;
        stall_pct     = 65;
        set_config(8'd0, 8'd0, 8'd0, 8'd0);
        run_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
        run_cmd(CMD_SEND, 8'h81, 1'b0, SDA_RANDOM);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_HIGH);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_LOW);
        run_cmd(CMD_READ, 8'h00, 1'b0, SDA_RANDOM);
        run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
    endtask

    // largest timeout, the poll count climbs to its top value
    task automatic test_max_delays();
        send_idle_pct = 26;
        stall_pct     = 26;
        set_config(8'd1, 8'd1, 8'd1, 8'd255);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_HIGH);
    endtask

    // one random tick: next planned command when idle, noise while busy
    task automatic random_tick();
        logic [2:0] f;
        f = 3'($urandom_range(7));
        if (seq_cmd == CMD_IDLE) begin
            if (plan_q.size() == 0) begin
                // mostly whole transactions, sometimes a lone command or noise
                if ($urandom_range(4) != 0) begin
                    plan_q.push_back(CMD_START);
                    plan_q.push_back(CMD_SEND);
                    plan_q.push_back(CMD_WAIT);
                    repeat ($urandom_range(1, 3)) begin
                        if ($urandom_range(1) != 0) begin
                            plan_q.push_back(CMD_SEND);
                            plan_q.push_back(CMD_WAIT);
                        end else begin
                            plan_q.push_back(CMD_READ);
                        end
                    end
                    plan_q.push_back(CMD_STOP);
                end else begin
                    plan_q.push_back(3'($urandom_range(7)));
                end
            end
            f = plan_q.pop_front();
            sda_mode = (f == CMD_WAIT && $urandom_range(2) == 0) ? SDA_HIGH : SDA_RANDOM;
        end
        send_tick(f, 8'($urandom), 1'($urandom), line_sda());
    endtask

    // random traffic over several register settings and idle patterns
    task automatic test_random_traffic();
        int n;
        for (int p = 0; p < 4; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 65; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            set_config(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                       8'($urandom_range(0, 3)), 8'($urandom_range(0, 20)));
            n = 0;
            while (n < 35 || seq_cmd != CMD_IDLE) begin
                random_tick();
                n++;
            end
        end
    endtask

    // test sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_unused_codes();
        test_ack_timeout();
        test_zero_delays();
        test_max_delays();
        test_random_traffic();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (line_q.size() != 0) $error("%0d expected results never arrived", line_q.size());
        $display("covered %0d ticks, %0d completed commands, %0d acknowledge timeouts",
                 n_ticks, n_done, n_timeouts);
        if (n_fail == 0 && line_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
